/* sv/pitb_pkg.sv */
`timescale 1ns / 1ps
// Package for the barycentric point-in-triangle pipeline.
// Holds coordinate and datapath widths, word layout and operand routing tables.
// No dependencies.
package pitb_pkg;

   localparam int COORD_WIDTH = 16;

   // word layout: twelve coordinates, A, B, C then P, x/y/z each
   localparam int NUM_AXES   = 3;
   localparam int NUM_FIELDS = 12;
   localparam int REQ_DATA_W = ((NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   localparam int FLD_A = 0;
   localparam int FLD_B = 1;
   localparam int FLD_C = 2;
   localparam int FLD_P = 3;

   // datapath widths
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int LO_W   = DOT_W / 2;
   localparam int HI_W   = DOT_W - LO_W;
   localparam int PART_W = HI_W + LO_W + 1;
   localparam int WIDE_W = 2 * DOT_W + 2;

   localparam int NUM_STAGES = 7;

   // edge vectors: e0 = C - A, e1 = B - A, q = P - A
   localparam int NUM_VECS = 3;
   localparam int VEC_E0   = 0;
   localparam int VEC_E1   = 1;
   localparam int VEC_Q    = 2;
   localparam int VEC_SRC [NUM_VECS] = '{FLD_C, FLD_B, FLD_P};

   // dot products d00, d01, d02, d11, d12
   localparam int NUM_DOTS = 5;
   localparam int D00 = 0;
   localparam int D01 = 1;
   localparam int D02 = 2;
   localparam int D11 = 3;
   localparam int D12 = 4;
   localparam int DOT_X [NUM_DOTS] = '{VEC_E0, VEC_E0, VEC_E0, VEC_E1, VEC_E1};
   localparam int DOT_Y [NUM_DOTS] = '{VEC_E0, VEC_E1, VEC_Q, VEC_E1, VEC_Q};

   // second-level products: den = m0 - m1, un = m2 - m3, vn = m4 - m5
   localparam int NUM_MULS = 6;
   localparam int MUL_A [NUM_MULS] = '{D00, D01, D11, D01, D00, D01};
   localparam int MUL_B [NUM_MULS] = '{D11, D01, D02, D12, D12, D02};

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic signed [PART_W-1:0]      part_type;
   typedef logic signed [WIDE_W-1:0]      wide_type;

endpackage

/* sv/point_in_triangle_barycentric_top.sv */
`timescale 1ns / 1ps
// Barycentric point-in-triangle test, seven-stage pipeline, one word per cycle unless the output stalls.
// Depends on pitb_pkg for widths, word layout and operand routing.
//
// Takes one query word per cycle when the output side is not stalled and returns
// one result word per query, in order. Stages: edge
// vectors, dot-product terms, dot sums, half-width partial products of the
// Gram terms, Gram products, den/un/vn, final compare. Every multiplier is
// registered on its own stage, so the rate is one word per cycle; a stalled
// output backs up only as far as the first empty stage, and bubbles collapse.
// All arithmetic is exact, so the inside test has no rounding; a collapsed
// triangle reports degenerate and outside.
module point_in_triangle_barycentric_top
   import pitb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // inside_res, degenerate, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   diff_type s1_vec_ff  [NUM_VECS][NUM_AXES];
   diff_type s1_vec_in  [NUM_VECS][NUM_AXES];
   prod_type s2_term_ff [NUM_DOTS][NUM_AXES];
   prod_type s2_term_in [NUM_DOTS][NUM_AXES];
   dot_type  s3_dot_ff  [NUM_DOTS];
   dot_type  s3_dot_in  [NUM_DOTS];
   part_type s4_hh_ff   [NUM_MULS];
   part_type s4_hh_in   [NUM_MULS];
   part_type s4_hl_ff   [NUM_MULS];
   part_type s4_hl_in   [NUM_MULS];
   part_type s4_lh_ff   [NUM_MULS];
   part_type s4_lh_in   [NUM_MULS];
   part_type s4_ll_ff   [NUM_MULS];
   part_type s4_ll_in   [NUM_MULS];
   wide_type s5_prod_ff [NUM_MULS];
   wide_type s5_prod_in [NUM_MULS];
   wide_type s6_den_ff, s6_den_in;
   wide_type s6_un_ff,  s6_un_in;
   wide_type s6_vn_ff,  s6_vn_in;
   wide_type s7_slack;
   logic     s7_inside_ff, s7_inside_in;
   logic     s7_degen_ff,  s7_degen_in;

   // a stage takes a word when it is empty or its word moves on
   assign ready[NUM_STAGES] = rsp_tready;
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_ready
      assign ready[g] = !valid_ff[g] || ready[g+1];
   end

   assign valid_in   = {valid_ff[NUM_STAGES-2:0], req_tvalid};
   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = RSP_DATA_W'({s7_degen_ff, s7_inside_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stage 1: edge vectors relative to A
   always_comb begin
      for (int v = 0; v < NUM_VECS; v++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            s1_vec_in[v][c] =
               DIFF_W'(coord_type'(req_tdata[(VEC_SRC[v]*NUM_AXES + c)*COORD_WIDTH +:
                                             COORD_WIDTH]))
               - DIFF_W'(coord_type'(req_tdata[(FLD_A*NUM_AXES + c)*COORD_WIDTH +:
                                               COORD_WIDTH]));
         end
      end
   end

   // stage 2: per-axis terms of the five dot products
   always_comb begin
      for (int d = 0; d < NUM_DOTS; d++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            s2_term_in[d][c] = prod_type'(s1_vec_ff[DOT_X[d]][c])
                             * prod_type'(s1_vec_ff[DOT_Y[d]][c]);
         end
      end
   end

   // stage 3: dot sums
   always_comb begin
      for (int d = 0; d < NUM_DOTS; d++) begin
         s3_dot_in[d] = DOT_W'(s2_term_ff[d][0]) + DOT_W'(s2_term_ff[d][1])
                      + DOT_W'(s2_term_ff[d][2]);
      end
   end

   // stage 4: split each Gram operand into a signed high and unsigned low half and multiply the halves
   always_comb begin
      dot_type                op_a;
      dot_type                op_b;
      logic signed [HI_W-1:0] a_hi;
      logic signed [HI_W-1:0] b_hi;
      logic signed [LO_W:0]   a_lo;
      logic signed [LO_W:0]   b_lo;
      for (int m = 0; m < NUM_MULS; m++) begin
         op_a = s3_dot_ff[MUL_A[m]];
         op_b = s3_dot_ff[MUL_B[m]];
         a_hi = op_a[DOT_W-1:LO_W];
         b_hi = op_b[DOT_W-1:LO_W];
         a_lo = $signed({1'b0, op_a[LO_W-1:0]});
         b_lo = $signed({1'b0, op_b[LO_W-1:0]});
         s4_hh_in[m] = part_type'(a_hi) * part_type'(b_hi);
         s4_hl_in[m] = part_type'(a_hi) * part_type'(b_lo);
         s4_lh_in[m] = part_type'(a_lo) * part_type'(b_hi);
         s4_ll_in[m] = part_type'(a_lo) * part_type'(b_lo);
      end
   end

   // stage 5: recombine partial products
   always_comb begin
      for (int m = 0; m < NUM_MULS; m++) begin
         s5_prod_in[m] = (WIDE_W'(s4_hh_ff[m]) <<< (2 * LO_W))
                       + ((WIDE_W'(s4_hl_ff[m]) + WIDE_W'(s4_lh_ff[m])) <<< LO_W)
                       + WIDE_W'(s4_ll_ff[m]);
      end
   end

   // stage 6: determinant and the two numerators
   assign s6_den_in = s5_prod_ff[0] - s5_prod_ff[1];
   assign s6_un_in  = s5_prod_ff[2] - s5_prod_ff[3];
   assign s6_vn_in  = s5_prod_ff[4] - s5_prod_ff[5];

   // stage 7: edges count as inside, so besides a zero determinant only strict negatives reject
   assign s7_slack     = s6_den_ff - s6_un_ff - s6_vn_ff;
   assign s7_degen_in  = (s6_den_ff == '0);
   assign s7_inside_in = !s7_degen_in && !s6_den_ff[WIDE_W-1] && !s6_un_ff[WIDE_W-1]
                       && !s6_vn_ff[WIDE_W-1] && !s7_slack[WIDE_W-1];

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_vec_ff <= s1_vec_in;
      end
      if (ready[1]) begin
         s2_term_ff <= s2_term_in;
      end
      if (ready[2]) begin
         s3_dot_ff <= s3_dot_in;
      end
      if (ready[3]) begin
         s4_hh_ff <= s4_hh_in;
         s4_hl_ff <= s4_hl_in;
         s4_lh_ff <= s4_lh_in;
         s4_ll_ff <= s4_ll_in;
      end
      if (ready[4]) begin
         s5_prod_ff <= s5_prod_in;
      end
      if (ready[5]) begin
         s6_den_ff <= s6_den_in;
         s6_un_ff  <= s6_un_in;
         s6_vn_ff  <= s6_vn_in;
      end
      if (ready[6]) begin
         s7_inside_ff <= s7_inside_in;
         s7_degen_ff  <= s7_degen_in;
      end
   end

   // any empty stage leaves room for a new word
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> req_tready)
      else $error("input stalled with an empty stage in the pipe");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   // a Gram determinant is never negative
   a_den_sign: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> !s6_den_ff[WIDE_W-1])
      else $error("negative determinant");

   a_degen_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s7_degen_ff |-> !s7_inside_ff)
      else $error("degenerate triangle reported inside");

endmodule

/* tb/sv/point_in_triangle_barycentric_top_test.sv */
`timescale 1ns / 1ps
// Testbench for point_in_triangle_barycentric_top: directed corner, edge and degenerate triangles,
// then full-range and shaped random queries, checked in order against an exact-integer barycentric predictor.
// Depends on pitb_pkg for the word layout and coordinate width.
module point_in_triangle_barycentric_top_test
   import pitb_pkg::*;
();

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RSP_INSIDE_BIT = 0;
   localparam int RSP_DEGEN_BIT  = 1;
   localparam int MAX_GAP        = 6;

   typedef logic signed [127:0] exact_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;
   typedef struct {
      bit inside_res;
      bit degenerate;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   verdict_type pending_verdicts[$];
   int          mismatches;
   int          cycles;
   int          queries_taken;
   int          inside_seen;
   int          degenerate_seen;
   bit          no_idle;

   point_in_triangle_barycentric_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact inside test on the raw query word
   function automatic verdict_type classify_point(input logic [REQ_DATA_W-1:0] word);
      coord_type   crd [NUM_FIELDS];
      diff_type    e0 [NUM_AXES];
      diff_type    e1 [NUM_AXES];
      diff_type    q [NUM_AXES];
      exact_type   d00, d01, d02, d11, d12, den, un, vn;
      verdict_type v;
      for (int f = 0; f < NUM_FIELDS; f++)
         crd[f] = word[f*COORD_WIDTH +: COORD_WIDTH];
      d00 = '0;
      d01 = '0;
      d02 = '0;
      d11 = '0;
      d12 = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         e0[k] = diff_type'(crd[FLD_C*NUM_AXES+k]) - diff_type'(crd[FLD_A*NUM_AXES+k]);
         e1[k] = diff_type'(crd[FLD_B*NUM_AXES+k]) - diff_type'(crd[FLD_A*NUM_AXES+k]);
         q[k]  = diff_type'(crd[FLD_P*NUM_AXES+k]) - diff_type'(crd[FLD_A*NUM_AXES+k]);
         d00 = d00 + exact_type'(e0[k]) * exact_type'(e0[k]);
         d01 = d01 + exact_type'(e0[k]) * exact_type'(e1[k]);
         d02 = d02 + exact_type'(e0[k]) * exact_type'(q[k]);
         d11 = d11 + exact_type'(e1[k]) * exact_type'(e1[k]);
         d12 = d12 + exact_type'(e1[k]) * exact_type'(q[k]);
      end
      den = d00 * d11 - d01 * d01;
      un  = d11 * d02 - d01 * d12;
      vn  = d00 * d12 - d01 * d02;
      v.degenerate = (den == 0);
      v.inside_res = (den > 0) && (un >= 0) && (vn >= 0) && (un + vn <= den);
      return v;
   endfunction

   function automatic vec3_type v3(input int x, input int y, input int z);
      vec3_type r;
      r.x = coord_type'(x);
      r.y = coord_type'(y);
      r.z = coord_type'(z);
      return r;
   endfunction

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic note_mismatch(input string what, input int expv, input int actv);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, expv, actv);
   endtask

   // one query word; valid stays high across back-to-back words
   task automatic send_query(input vec3_type a, input vec3_type b, input vec3_type c,
                             input vec3_type p);
      vec3_type              pts [4];
      logic [REQ_DATA_W-1:0] word;
      int                    gap;
      pts[FLD_A] = a;
      pts[FLD_B] = b;
      pts[FLD_C] = c;
      pts[FLD_P] = p;
      word = '0;
      for (int i = 0; i < 4; i++) begin
         word[(i*NUM_AXES+0)*COORD_WIDTH +: COORD_WIDTH] = pts[i].x;
         word[(i*NUM_AXES+1)*COORD_WIDTH +: COORD_WIDTH] = pts[i].y;
         word[(i*NUM_AXES+2)*COORD_WIDTH +: COORD_WIDTH] = pts[i].z;
      end
      gap = no_idle ? 0 : int'($urandom_range(MAX_GAP));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every pending result is back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic test_extremes();
      send_query(v3(-32768, -32768, -32768), v3(-32768, -32768, -32768),
                 v3(-32768, -32768, -32768), v3(-32768, -32768, -32768));
      send_query(v3(32767, 32767, 32767), v3(32767, 32767, 32767),
                 v3(32767, 32767, 32767), v3(32767, 32767, 32767));
      send_query(v3(-32768, -32768, -32768), v3(32767, -32768, -32768),
                 v3(-32768, 32767, -32768), v3(32767, 32767, 32767));
      send_query(v3(-32768, -32768, -32768), v3(32767, -32768, -32768),
                 v3(-32768, 32767, -32768), v3(0, 0, 32767));
      send_query(v3(-32768, -32768, -32768), v3(32767, -32768, -32768),
                 v3(-32768, 32767, -32768), v3(-32768, -32768, 32767));
      send_query(v3(32767, 32767, 32767), v3(-32768, 32767, 32767),
                 v3(32767, -32768, -32768), v3(-32768, -32768, -32768));
      send_query(v3(32767, -32768, 32767), v3(-32768, 32767, -32768),
                 v3(32767, 32767, -32768), v3(32767, -32768, 32767));
      send_query(v3(-32768, 32767, 0), v3(32767, -32768, 0),
                 v3(32767, 32767, 0), v3(0, 0, -32768));
   endtask

   task automatic test_edges_and_degenerate();
      vec3_type a, b, c;
      a = v3(0, 0, 0);
      b = v3(100, 0, 0);
      c = v3(0, 100, 0);
      // vertices and edges count as inside
      send_query(a, b, c, a);
      send_query(a, b, c, b);
      send_query(a, b, c, c);
      send_query(a, b, c, v3(50, 0, 0));
      send_query(a, b, c, v3(50, 50, 0));
      send_query(a, b, c, v3(0, 50, 0));
      send_query(a, b, c, v3(20, 20, 0));
      // projected onto the plane before the test
      send_query(a, b, c, v3(20, 20, 5000));
      send_query(a, b, c, v3(51, 50, 0));
      send_query(a, b, c, v3(-1, 0, 0));
      // collapsed to a point, then to a segment
      send_query(a, a, a, a);
      send_query(a, v3(10, 10, 10), v3(20, 20, 20), v3(10, 10, 10));
      send_query(v3(5, -7, 3), v3(5, -7, 3), v3(9, 1, -4), v3(200, 300, 400));
   endtask

   task automatic test_full_range(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            no_idle = ($urandom_range(3) == 0);
         send_query(v3($urandom, $urandom, $urandom), v3($urandom, $urandom, $urandom),
                    v3($urandom, $urandom, $urandom), v3($urandom, $urandom, $urandom));
      end
      no_idle = 1'b0;
      wait_for_drain();
   endtask

   // triangles with points placed by barycentric weights, on vertices and edge midpoints,
   // and collinear triangles
   task automatic test_shaped_triangles(input int count);
      int a [NUM_AXES];
      int e0 [NUM_AXES];
      int e1 [NUM_AXES];
      int p [NUM_AXES];
      int span, shape, k, wb, wc, n, corner;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0)
            no_idle = ($urandom_range(3) == 0);
         if (i == count / 2)
            wait_for_drain();
         span  = ($urandom_range(9) == 0) ? 2500 : 200;
         shape = $urandom_range(9);
         k      = pick(-3, 3);
         corner = $urandom_range(2);
         wb = $urandom_range(4);
         wc = $urandom_range(4);
         n  = pick(1, 4);
         for (int j = 0; j < NUM_AXES; j++) begin
            a[j]  = pick(-10000, 10000);
            e1[j] = pick(-span, span);
            e0[j] = pick(-span, span);
         end
         for (int j = 0; j < NUM_AXES; j++) begin
            case (shape)
               0: begin
                  e0[j] = k * e1[j];
                  p[j]  = a[j] + pick(-span, span);
               end
               1: begin
                  p[j] = a[j] + (corner == 1 ? e1[j] : 0) + (corner == 2 ? e0[j] : 0);
               end
               2: begin
                  e1[j] = e1[j] & ~1;
                  e0[j] = e0[j] & ~1;
                  p[j]  = a[j] + ((corner != 1 ? e1[j] : 0) + (corner != 0 ? e0[j] : 0)) / 2;
               end
               default: begin
                  p[j] = a[j] + (wb * e1[j] + wc * e0[j]) / n;
                  if (shape > 6)
                     p[j] = p[j] + pick(-300, 300);
               end
            endcase
         end
         send_query(v3(a[0], a[1], a[2]), v3(a[0] + e1[0], a[1] + e1[1], a[2] + e1[2]),
                    v3(a[0] + e0[0], a[1] + e0[1], a[2] + e0[2]), v3(p[0], p[1], p[2]));
      end
      no_idle = 1'b0;
   endtask

   // result side: random stall ahead of each word
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : int'($urandom_range(MAX_GAP));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // check results first so a stray word never borrows the expectation of a fresh query
   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               note_mismatch("unexpected result word, inside", 0,
                             int'(rsp_tdata[RSP_INSIDE_BIT]));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[RSP_INSIDE_BIT] !== want.inside_res)
                  note_mismatch("inside_res", int'(want.inside_res),
                                int'(rsp_tdata[RSP_INSIDE_BIT]));
               if (rsp_tdata[RSP_DEGEN_BIT] !== want.degenerate)
                  note_mismatch("degenerate", int'(want.degenerate),
                                int'(rsp_tdata[RSP_DEGEN_BIT]));
            end
         end
         if (req_tvalid && req_tready) begin
            want = classify_point(req_tdata);
            pending_verdicts.push_back(want);
            queries_taken++;
            inside_seen     += int'(want.inside_res);
            degenerate_seen += int'(want.degenerate);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  pending_verdicts.size());
         $display("FAIL point_in_triangle_barycentric_top");
         $finish;
      end
   end

   initial begin
      mismatches      = 0;
      cycles          = 0;
      queries_taken   = 0;
      inside_seen     = 0;
      degenerate_seen = 0;
      no_idle         = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_edges_and_degenerate();
      test_full_range(150);
      test_shaped_triangles(640);

      wait_for_drain();
      repeat (4 * NUM_STAGES) @(posedge clock);
      if (pending_verdicts.size() != 0)
         note_mismatch("results never returned", 0, pending_verdicts.size());

      $display("Covered %0d queries (%0d inside, %0d degenerate): corner coordinates,",
               queries_taken, inside_seen, degenerate_seen);
      $display("vertex and edge points, collapsed triangles, full-range and shaped random.");
      if (mismatches == 0) begin
         $display("PASS point_in_triangle_barycentric_top");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL point_in_triangle_barycentric_top");
      end
      $finish;
   end

endmodule

/* files.f */
sv/pitb_pkg.sv
sv/point_in_triangle_barycentric_top.sv
tb/sv/point_in_triangle_barycentric_top_test.sv
